[hdl/bumm_pkg.sv]
// Shared definitions for the broadcast/unicast mailbox: default sizes, operation
// and status codes, and the command and status bundles between controller and datapath.
// No dependencies.
`default_nettype none

package bumm_pkg;

    localparam int MAX_READERS_DEF     = 8;
    localparam int BROADCAST_DEPTH_DEF = 32;
    localparam int PRIVATE_DEPTH_DEF   = 32;
    localparam int PAYLOAD_WIDTH_DEF   = 32;
    localparam int SEQ_WIDTH_DEF       = 16;

    // Widths fixed by the port list.
    localparam int OP_W      = 2;
    localparam int READER_W  = 3;
    localparam int MSG_W     = 32;
    localparam int STATUS_W  = 3;
    localparam int CFG_W     = 4;
    localparam int WIDE_W    = 48;
    localparam int CNT_W     = 7;

    // A poll delivers at most this many messages.
    localparam int RESULT_LIMIT = 64;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_ONE = 2'd0,
        OP_PUSH_ALL = 2'd1,
        OP_POLL     = 2'd2,
        OP_NONE     = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_ACCEPTED   = 3'd0,
        ST_DELIVERED  = 3'd1,
        ST_NOTHING    = 3'd2,
        ST_BAD_READER = 3'd3,
        ST_FULL       = 3'd4
    } status_t;

    typedef struct packed {
        logic accept;
        logic issue_read;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic poll_go;
        logic emit_last;
    } dp_status_t;

endpackage

`default_nettype wire

[hdl/broadcast_unicast_mailbox_merge.sv]
// Top level of the broadcast/unicast mailbox: controller plus datapath.
// Depends on bumm_pkg, bumm_ctrl and bumm_datapath.
`default_nettype none

// A command is taken when start is high and busy is low. A private push
// (op 0) or a broadcast push (op 1) leaves busy low, and its single result
// transfer appears on the result ports in the next cycle, so pushes can be
// issued back to back. A poll (op 2) that has messages waiting raises busy
// and delivers them oldest stamp first, one at a time: each delivery has a
// read step that reads both ring stores at the reader's cursors and an emit
// step that compares stamps and emits. A poll delivers at most 64 messages
// and takes no new command until its last one; a poll that is rejected or
// finds nothing answers in the next cycle and leaves busy low. Every result
// is valid for exactly one cycle and last marks the final transfer of a
// command; the receiver cannot stall the block, so it must take each
// transfer when valid is high. A write to the reader count register
// empties the mailbox and must be issued only while the block is idle.
module broadcast_unicast_mailbox_merge #(
    parameter int MAX_READERS     = bumm_pkg::MAX_READERS_DEF,
    parameter int BROADCAST_DEPTH = bumm_pkg::BROADCAST_DEPTH_DEF,
    parameter int PRIVATE_DEPTH   = bumm_pkg::PRIVATE_DEPTH_DEF,
    parameter int PAYLOAD_WIDTH   = bumm_pkg::PAYLOAD_WIDTH_DEF,
    parameter int SEQ_WIDTH       = bumm_pkg::SEQ_WIDTH_DEF
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               start,
    output logic                              busy,
    input  wire                               cfg_we,
    input  wire  [bumm_pkg::CFG_W-1:0]        cfg_wdata,
    input  wire  [bumm_pkg::OP_W-1:0]         op,
    input  wire  [bumm_pkg::READER_W-1:0]     reader,
    input  wire  [bumm_pkg::MSG_W-1:0]        message,
    output logic                              valid,
    output logic [bumm_pkg::MSG_W-1:0]        payload,
    output logic [bumm_pkg::STATUS_W-1:0]     status,
    output logic                              from_broadcast,
    output logic                              last
);
    import bumm_pkg::*;

    // Commands from the controller and status back from the datapath.
    ctrl_cmd_t  cmd;
    dp_status_t dp_st;

    bumm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .dp_st (dp_st),
        .cmd   (cmd),
        .busy  (busy)
    );

    bumm_datapath #(
        .MAX_READERS     (MAX_READERS),
        .BROADCAST_DEPTH (BROADCAST_DEPTH),
        .PRIVATE_DEPTH   (PRIVATE_DEPTH),
        .PAYLOAD_WIDTH   (PAYLOAD_WIDTH),
        .SEQ_WIDTH       (SEQ_WIDTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .dp_st          (dp_st),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .op             (op),
        .reader         (reader),
        .message        (message),
        .valid          (valid),
        .payload        (payload),
        .status         (status),
        .from_broadcast (from_broadcast),
        .last           (last)
    );

endmodule

`default_nettype wire

[hdl/bumm_ctrl.sv]
// Controller of the mailbox: sequences a poll through read and emit steps.
// Depends on bumm_pkg.
`default_nettype none

module bumm_ctrl (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   start,
    input  bumm_pkg::dp_status_t  dp_st,
    output bumm_pkg::ctrl_cmd_t   cmd,
    output logic                  busy
);
    import bumm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_EMIT = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start && dp_st.poll_go)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                state_next = dp_st.emit_last ? S_IDLE : S_READ;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy           = (state_reg != S_IDLE);
    assign cmd.accept     = start && (state_reg == S_IDLE);
    assign cmd.issue_read = (state_reg == S_READ);
    assign cmd.emit       = (state_reg == S_EMIT);

endmodule

`default_nettype wire

[hdl/bumm_datapath.sv]
// Datapath of the mailbox: ring stores, write counts, read cursors, the
// sequence counter, the stamp merge and the registered result.
// Depends on bumm_pkg.
`default_nettype none

module bumm_datapath #(
    parameter int MAX_READERS     = bumm_pkg::MAX_READERS_DEF,
    parameter int BROADCAST_DEPTH = bumm_pkg::BROADCAST_DEPTH_DEF,
    parameter int PRIVATE_DEPTH   = bumm_pkg::PRIVATE_DEPTH_DEF,
    parameter int PAYLOAD_WIDTH   = bumm_pkg::PAYLOAD_WIDTH_DEF,
    parameter int SEQ_WIDTH       = bumm_pkg::SEQ_WIDTH_DEF
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  bumm_pkg::ctrl_cmd_t               cmd,
    output bumm_pkg::dp_status_t              dp_st,
    input  wire                               cfg_we,
    input  wire  [bumm_pkg::CFG_W-1:0]        cfg_wdata,
    input  wire  [bumm_pkg::OP_W-1:0]         op,
    input  wire  [bumm_pkg::READER_W-1:0]     reader,
    input  wire  [bumm_pkg::MSG_W-1:0]        message,
    output logic                              valid,
    output logic [bumm_pkg::MSG_W-1:0]        payload,
    output logic [bumm_pkg::STATUS_W-1:0]     status,
    output logic                              from_broadcast,
    output logic                              last
);
    import bumm_pkg::*;

    localparam int RW  = (MAX_READERS > 1) ? $clog2(MAX_READERS) : 1;
    localparam int BCW = $clog2(2 * BROADCAST_DEPTH);
    localparam int BIW = $clog2(BROADCAST_DEPTH);
    localparam int PCW = $clog2(2 * PRIVATE_DEPTH);
    localparam int PIW = $clog2(PRIVATE_DEPTH);
    localparam int PAW = $clog2(MAX_READERS * PRIVATE_DEPTH);
    localparam int EW  = PAYLOAD_WIDTH + SEQ_WIDTH;

    // Stores hold {stamp, payload}.
    logic [EW-1:0] bmem [BROADCAST_DEPTH];
    logic [EW-1:0] pmem [MAX_READERS * PRIVATE_DEPTH];
    logic [EW-1:0] brd_reg;
    logic [EW-1:0] prd_reg;

    logic [BCW-1:0]       bwc_reg,  bwc_next;
    logic [PCW-1:0]       pwc_reg  [MAX_READERS];
    logic [PCW-1:0]       pwc_next [MAX_READERS];
    logic [BCW-1:0]       bcur_reg [MAX_READERS];
    logic [BCW-1:0]       bcur_next[MAX_READERS];
    logic [PCW-1:0]       pcur_reg [MAX_READERS];
    logic [PCW-1:0]       pcur_next[MAX_READERS];
    logic [SEQ_WIDTH-1:0] seq_reg,  seq_next;
    logic [CFG_W-1:0]     rc_reg,   rc_next;
    logic [RW-1:0]        rid_reg,  rid_next;
    logic [PCW-1:0]       pn_reg,   pn_next;
    logic [BCW-1:0]       bn_reg,   bn_next;
    logic [CNT_W-1:0]     k_reg,    k_next;

    logic                 valid_reg, valid_next;
    logic [MSG_W-1:0]     pay_reg,   pay_next;
    logic [STATUS_W-1:0]  st_reg,    st_next;
    logic                 fb_reg,    fb_next;
    logic                 last_reg,  last_next;

    // Decode of the incoming item.
    logic [CNT_W-1:0]     n_act;
    logic [CNT_W-1:0]     r_ext;
    logic                 bad;
    logic [RW-1:0]        rid_in;
    logic [PCW-1:0]       pdist, pn_in;
    logic [BCW-1:0]       bdist, bn_in;
    logic [PCW:0]         pdist_w;
    logic [BCW:0]         bdist_w, bdi_w;
    logic [MAX_READERS-1:0] bfull;
    logic [WIDE_W-1:0]    msg_wide;
    logic [PAYLOAD_WIDTH-1:0] msg_kept;

    // Store write and read addressing.
    logic                 bwe, pwe;
    logic [BIW-1:0]       bwaddr, braddr;
    logic [PAW-1:0]       pwaddr, praddr;
    logic [PIW-1:0]       pw_idx, pr_idx;

    // Merge.
    logic [SEQ_WIDTH-1:0] ps_stamp, bs_stamp, sdiff;
    logic                 take_p;
    logic [PCW-1:0]       pn_after;
    logic [BCW-1:0]       bn_after;
    logic                 emit_last;
    logic [WIDE_W-1:0]    sel_wide;

    always_comb
    begin
        n_act  = ({3'b000, rc_reg} > CNT_W'(MAX_READERS)) ? CNT_W'(MAX_READERS)
                                                         : {3'b000, rc_reg};
        r_ext  = {4'b0000, reader};
        bad    = (r_ext >= n_act);
        rid_in = r_ext[RW-1:0];

        pdist_w = {1'b0, pwc_reg[rid_in]} + (PCW+1)'(2 * PRIVATE_DEPTH)
                  - {1'b0, pcur_reg[rid_in]};
        pdist   = (pwc_reg[rid_in] >= pcur_reg[rid_in])
                  ? PCW'(pwc_reg[rid_in] - pcur_reg[rid_in]) : pdist_w[PCW-1:0];
        bdist_w = {1'b0, bwc_reg} + (BCW+1)'(2 * BROADCAST_DEPTH) - {1'b0, bcur_reg[rid_in]};
        bdist   = (bwc_reg >= bcur_reg[rid_in])
                  ? BCW'(bwc_reg - bcur_reg[rid_in]) : bdist_w[BCW-1:0];
        pn_in   = (pdist > PCW'(PRIVATE_DEPTH)) ? PCW'(PRIVATE_DEPTH) : pdist;
        bn_in   = (bdist > BCW'(BROADCAST_DEPTH)) ? BCW'(BROADCAST_DEPTH) : bdist;

        for (int i = 0; i < MAX_READERS; i++)
        begin
            bdi_w    = {1'b0, bwc_reg} + (BCW+1)'(2 * BROADCAST_DEPTH) - {1'b0, bcur_reg[i]};
            bfull[i] = (CNT_W'(i) < n_act) &&
                       (((bwc_reg >= bcur_reg[i]) ? BCW'(bwc_reg - bcur_reg[i])
                                                  : bdi_w[BCW-1:0])
                        >= BCW'(BROADCAST_DEPTH));
        end

        msg_wide = WIDE_W'(message);
        msg_kept = msg_wide[PAYLOAD_WIDTH-1:0];

        bwaddr = (bwc_reg >= BCW'(BROADCAST_DEPTH)) ? BIW'(bwc_reg - BCW'(BROADCAST_DEPTH))
                                                    : BIW'(bwc_reg);
        pw_idx = (pwc_reg[rid_in] >= PCW'(PRIVATE_DEPTH))
                 ? PIW'(pwc_reg[rid_in] - PCW'(PRIVATE_DEPTH)) : PIW'(pwc_reg[rid_in]);
        pwaddr = PAW'(rid_in) * PAW'(PRIVATE_DEPTH) + PAW'(pw_idx);

        braddr = (bcur_reg[rid_reg] >= BCW'(BROADCAST_DEPTH))
                 ? BIW'(bcur_reg[rid_reg] - BCW'(BROADCAST_DEPTH)) : BIW'(bcur_reg[rid_reg]);
        pr_idx = (pcur_reg[rid_reg] >= PCW'(PRIVATE_DEPTH))
                 ? PIW'(pcur_reg[rid_reg] - PCW'(PRIVATE_DEPTH)) : PIW'(pcur_reg[rid_reg]);
        praddr = PAW'(rid_reg) * PAW'(PRIVATE_DEPTH) + PAW'(pr_idx);

        // Private wins when its stamp is not newer than the broadcast stamp.
        ps_stamp  = prd_reg[EW-1:PAYLOAD_WIDTH];
        bs_stamp  = brd_reg[EW-1:PAYLOAD_WIDTH];
        sdiff     = bs_stamp - ps_stamp;
        take_p    = (bn_reg == '0) || ((pn_reg != '0) && !sdiff[SEQ_WIDTH-1]);
        pn_after  = take_p ? PCW'(pn_reg - PCW'(1)) : pn_reg;
        bn_after  = take_p ? bn_reg : BCW'(bn_reg - BCW'(1));
        emit_last = ((pn_after == '0) && (bn_after == '0))
                    || (k_reg == CNT_W'(RESULT_LIMIT - 1));
        sel_wide  = take_p ? WIDE_W'(prd_reg[PAYLOAD_WIDTH-1:0])
                           : WIDE_W'(brd_reg[PAYLOAD_WIDTH-1:0]);
    end

    assign dp_st.poll_go   = (op == OP_POLL) && !bad && ((pn_in != '0) || (bn_in != '0));
    assign dp_st.emit_last = emit_last;

    always_comb
    begin
        bwc_next   = bwc_reg;
        pwc_next   = pwc_reg;
        bcur_next  = bcur_reg;
        pcur_next  = pcur_reg;
        seq_next   = seq_reg;
        rc_next    = rc_reg;
        rid_next   = rid_reg;
        pn_next    = pn_reg;
        bn_next    = bn_reg;
        k_next     = k_reg;
        valid_next = 1'b0;
        pay_next   = '0;
        st_next    = ST_NOTHING;
        fb_next    = 1'b0;
        last_next  = 1'b1;
        bwe        = 1'b0;
        pwe        = 1'b0;

        if (cfg_we)
        begin
            // A register write also empties the mailbox.
            bwc_next = '0;
            seq_next = '0;
            rc_next  = cfg_wdata;
            for (int i = 0; i < MAX_READERS; i++)
            begin
                pwc_next[i]  = '0;
                bcur_next[i] = '0;
                pcur_next[i] = '0;
            end
        end
        else if (cmd.accept)
        begin
            valid_next = 1'b1;
            unique case (op_t'(op))
                OP_PUSH_ONE:
                begin
                    if (bad)
                    begin
                        st_next = ST_BAD_READER;
                    end
                    else if (pdist >= PCW'(PRIVATE_DEPTH))
                    begin
                        st_next = ST_FULL;
                    end
                    else
                    begin
                        pwe              = 1'b1;
                        pwc_next[rid_in] = (pwc_reg[rid_in] == PCW'(2 * PRIVATE_DEPTH - 1))
                                           ? '0 : PCW'(pwc_reg[rid_in] + PCW'(1));
                        seq_next         = seq_reg + SEQ_WIDTH'(1);
                        st_next          = ST_ACCEPTED;
                    end
                end
                OP_PUSH_ALL:
                begin
                    if (|bfull)
                    begin
                        st_next = ST_FULL;
                    end
                    else
                    begin
                        bwe      = 1'b1;
                        bwc_next = (bwc_reg == BCW'(2 * BROADCAST_DEPTH - 1))
                                   ? '0 : BCW'(bwc_reg + BCW'(1));
                        seq_next = seq_reg + SEQ_WIDTH'(1);
                        st_next  = ST_ACCEPTED;
                    end
                end
                OP_POLL:
                begin
                    if (bad)
                    begin
                        st_next = ST_BAD_READER;
                    end
                    else if (dp_st.poll_go)
                    begin
                        // Results follow from the emit steps.
                        valid_next = 1'b0;
                        rid_next   = rid_in;
                        pn_next    = pn_in;
                        bn_next    = bn_in;
                        k_next     = '0;
                    end
                    else
                    begin
                        st_next = ST_NOTHING;
                    end
                end
                default:
                begin
                    st_next = ST_NOTHING;
                end
            endcase
        end
        else if (cmd.emit)
        begin
            valid_next = 1'b1;
            st_next    = ST_DELIVERED;
            pay_next   = sel_wide[MSG_W-1:0];
            fb_next    = !take_p;
            last_next  = emit_last;
            pn_next    = pn_after;
            bn_next    = bn_after;
            k_next     = k_reg + CNT_W'(1);
            if (take_p)
            begin
                pcur_next[rid_reg] = (pcur_reg[rid_reg] == PCW'(2 * PRIVATE_DEPTH - 1))
                                     ? '0 : PCW'(pcur_reg[rid_reg] + PCW'(1));
            end
            else
            begin
                bcur_next[rid_reg] = (bcur_reg[rid_reg] == BCW'(2 * BROADCAST_DEPTH - 1))
                                     ? '0 : BCW'(bcur_reg[rid_reg] + BCW'(1));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bwc_reg   <= '0;
            seq_reg   <= '0;
            rc_reg    <= CFG_W'(1);
            rid_reg   <= '0;
            pn_reg    <= '0;
            bn_reg    <= '0;
            k_reg     <= '0;
            valid_reg <= 1'b0;
            for (int i = 0; i < MAX_READERS; i++)
            begin
                pwc_reg[i]  <= '0;
                bcur_reg[i] <= '0;
                pcur_reg[i] <= '0;
            end
        end
        else
        begin
            bwc_reg   <= bwc_next;
            pwc_reg   <= pwc_next;
            bcur_reg  <= bcur_next;
            pcur_reg  <= pcur_next;
            seq_reg   <= seq_next;
            rc_reg    <= rc_next;
            rid_reg   <= rid_next;
            pn_reg    <= pn_next;
            bn_reg    <= bn_next;
            k_reg     <= k_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pay_reg  <= pay_next;
        st_reg   <= st_next;
        fb_reg   <= fb_next;
        last_reg <= last_next;
    end

    always_ff @(posedge clk)
    begin
        if (bwe)
        begin
            bmem[bwaddr] <= {seq_reg, msg_kept};
        end
        if (cmd.issue_read)
        begin
            brd_reg <= bmem[braddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pwe)
        begin
            pmem[pwaddr] <= {seq_reg, msg_kept};
        end
        if (cmd.issue_read)
        begin
            prd_reg <= pmem[praddr];
        end
    end

    assign valid          = valid_reg;
    assign payload        = pay_reg;
    assign status         = st_reg;
    assign from_broadcast = fb_reg;
    assign last           = last_reg;

`ifndef SYNTH
    a_emit_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> ((pn_reg != '0) || (bn_reg != '0)))
        else $error("emit step with no pending message");
    a_k_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        k_reg <= CNT_W'(RESULT_LIMIT))
        else $error("poll delivered beyond the result limit");
    a_fb_delivered: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && fb_reg) |-> (st_reg == ST_DELIVERED))
        else $error("broadcast flag on a non-delivery result");
    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> (valid_reg && (st_reg == ST_DELIVERED)))
        else $error("emit step produced no delivery");
`endif

endmodule

`default_nettype wire
